>>> rtl/button_auto_repeat_adjuster_defines.svh
// Assertion macros shared by the button auto-repeat adjuster RTL.
`ifndef BUTTON_AUTO_REPEAT_ADJUSTER_DEFINES_SVH
`define BUTTON_AUTO_REPEAT_ADJUSTER_DEFINES_SVH

`ifndef SYNTHESIS

`define BAR_ASSERT_IMPL(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("implication check failed");

`define BAR_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("next-cycle check failed");

`else

`define BAR_ASSERT_IMPL(lbl, pre, post)

`define BAR_ASSERT_NEXT(lbl, pre, post)

`endif

`endif

>>> rtl/bar_pkg.sv
// Package: types, codes, constants and helpers of the button auto-repeat adjuster.
`timescale 1ns / 1ps

package bar_pkg;

    localparam int TIME_W  = 32;
    localparam int VALUE_W = 32;
    localparam int DC_W    = 16;
    localparam int CFG_IDX_W = 3;

    localparam logic [TIME_W-1:0] SETTLE_MS        = TIME_W'(500);
    localparam logic [TIME_W-1:0] INITIAL_DELAY_MS = TIME_W'(500);
    localparam logic [TIME_W-1:0] FAST_HOLD_MS     = TIME_W'(3000);
    localparam logic [TIME_W-1:0] SLOW_PERIOD_MS   = TIME_W'(150);
    localparam logic [TIME_W-1:0] FAST_PERIOD_MS   = TIME_W'(75);
    localparam logic [VALUE_W-1:0] BYTE_LIMIT      = VALUE_W'(255);

    typedef enum logic [1:0] {
        CMD_TICK = 2'd0,
        CMD_HIT  = 2'd1,
        CMD_MENU = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ACT_REFRESH = 2'd0,
        ACT_STEP    = 2'd1,
        ACT_RESET   = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        KIND_BOOL = 2'd0,
        KIND_BYTE = 2'd1,
        KIND_WORD = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        MODE_TOGGLE = 2'd0,
        MODE_INCR   = 2'd1,
        MODE_ADD    = 2'd2
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_VALUE_KIND  = 3'd0,
        REG_ADJUST_MODE = 3'd1,
        REG_MIN_VALUE   = 3'd2,
        REG_MAX_VALUE   = 3'd3,
        REG_STEP_SIZE   = 3'd4,
        REG_DOUBLE_CLICK = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [1:0]         command;
        logic               hit_is_enter;
        logic               enter_level;
        logic [VALUE_W-1:0] load_value;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         action;
        logic [VALUE_W-1:0] display_value;
        logic [VALUE_W-1:0] saved_value;
    } out_item_t;

    typedef struct packed {
        logic [1:0]         value_kind;
        logic [1:0]         adjust_mode;
        logic [VALUE_W-1:0] min_value;
        logic [VALUE_W-1:0] max_value;
        logic [VALUE_W-1:0] step_size;
        logic [DC_W-1:0]    double_click_ms;
    } cfg_t;

    typedef struct packed {
        logic [TIME_W-1:0]  now_ms;
        logic [TIME_W-1:0]  menu_change_time;
        logic [TIME_W-1:0]  last_hit_time;
        logic [TIME_W-1:0]  press_start_time;
        logic [TIME_W-1:0]  last_repeat_time;
        logic [VALUE_W-1:0] current_value;
        logic               enter_pending;
        logic               reset_pending;
        logic               was_pressed;
    } state_t;

    function automatic logic [VALUE_W-1:0] saturate(input logic [1:0] kind,
                                                    input logic [VALUE_W-1:0] v);
        logic [VALUE_W-1:0] r;
        r = v;
        if (kind == KIND_BOOL)
        begin
            r = (v != '0) ? VALUE_W'(1) : '0;
        end
        else if (kind == KIND_BYTE)
        begin
            r = (v > BYTE_LIMIT) ? BYTE_LIMIT : v;
        end
        return r;
    endfunction

endpackage

>>> rtl/bar_cfg_regs.sv
// Configuration register bank of the button auto-repeat adjuster.
`timescale 1ns / 1ps

module bar_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           wr_en,
    input  logic [bar_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [bar_pkg::VALUE_W-1:0]    wr_data,
    output bar_pkg::cfg_t                  cfg
);

    bar_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.value_kind      <= bar_pkg::KIND_BYTE;
            cfg_reg.adjust_mode     <= bar_pkg::MODE_INCR;
            cfg_reg.min_value       <= '0;
            cfg_reg.max_value       <= bar_pkg::VALUE_W'(255);
            cfg_reg.step_size       <= bar_pkg::VALUE_W'(1);
            cfg_reg.double_click_ms <= bar_pkg::DC_W'(300);
        end
        else if (wr_en)
        begin
            case (wr_index)
                bar_pkg::REG_VALUE_KIND:   cfg_reg.value_kind      <= wr_data[1:0];
                bar_pkg::REG_ADJUST_MODE:  cfg_reg.adjust_mode     <= wr_data[1:0];
                bar_pkg::REG_MIN_VALUE:    cfg_reg.min_value       <= wr_data;
                bar_pkg::REG_MAX_VALUE:    cfg_reg.max_value       <= wr_data;
                bar_pkg::REG_STEP_SIZE:    cfg_reg.step_size       <= wr_data;
                bar_pkg::REG_DOUBLE_CLICK:
                    cfg_reg.double_click_ms <= wr_data[bar_pkg::DC_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/bar_step.sv
// Per-beat update logic: next state and optional result for one input item.
`timescale 1ns / 1ps

module bar_step (
    input  bar_pkg::cfg_t      cfg,
    input  bar_pkg::state_t    st,
    input  bar_pkg::in_item_t  item,
    output bar_pkg::state_t    st_next,
    output logic               res_valid,
    output bar_pkg::out_item_t res
);

    logic [bar_pkg::TIME_W-1:0]  now_t;
    logic [bar_pkg::TIME_W-1:0]  since_menu;
    logic [bar_pkg::TIME_W-1:0]  since_hit;
    logic [bar_pkg::TIME_W-1:0]  hold;
    logic [bar_pkg::TIME_W-1:0]  since_rep;
    logic [bar_pkg::VALUE_W-1:0] stepped;
    logic [bar_pkg::VALUE_W-1:0] sum;
    logic [bar_pkg::VALUE_W-1:0] load_sat;
    logic [bar_pkg::VALUE_W-1:0] step_sat;
    logic                        repeat_due;

    // a tick advances time before any elapsed check
    assign now_t      = (item.command == bar_pkg::CMD_TICK) ? st.now_ms + 1'b1 : st.now_ms;
    assign since_menu = now_t - st.menu_change_time;
    assign since_hit  = st.now_ms - st.last_hit_time;
    assign hold       = now_t - st.press_start_time;
    assign since_rep  = now_t - st.last_repeat_time;
    assign sum        = st.current_value + cfg.step_size;

    always_comb
    begin
        case (cfg.adjust_mode)
            bar_pkg::MODE_TOGGLE: stepped = (st.current_value != '0) ? '0
                                                                     : bar_pkg::VALUE_W'(1);
            bar_pkg::MODE_INCR:   stepped = (st.current_value < cfg.max_value)
                                            ? st.current_value + 1'b1 : cfg.min_value;
            bar_pkg::MODE_ADD:    stepped = (sum > cfg.max_value) ? cfg.min_value : sum;
            default:              stepped = st.current_value;
        endcase
    end

    assign load_sat = bar_pkg::saturate(cfg.value_kind, item.load_value);
    assign step_sat = bar_pkg::saturate(cfg.value_kind, stepped);

    assign repeat_due = (hold >= bar_pkg::INITIAL_DELAY_MS) &&
                        ((since_rep >= bar_pkg::SLOW_PERIOD_MS) ||
                         ((since_rep >= bar_pkg::FAST_PERIOD_MS) &&
                          (hold >= bar_pkg::FAST_HOLD_MS)));

    always_comb
    begin
        st_next   = st;
        res_valid = 1'b0;
        res       = '0;
        case (item.command)
            bar_pkg::CMD_MENU:
            begin
                st_next.menu_change_time = st.now_ms;
                st_next.current_value    = load_sat;
                res_valid                = 1'b1;
                res.action               = bar_pkg::ACT_REFRESH;
                res.display_value        = load_sat;
                res.saved_value          = load_sat;
            end
            bar_pkg::CMD_HIT:
            begin
                if ((since_menu >= bar_pkg::SETTLE_MS) && item.hit_is_enter)
                begin
                    if (since_hit < bar_pkg::TIME_W'(cfg.double_click_ms))
                        st_next.reset_pending = 1'b1;
                    else
                        st_next.enter_pending = 1'b1;
                    st_next.last_hit_time = st.now_ms;
                end
            end
            bar_pkg::CMD_TICK:
            begin
                st_next.now_ms = now_t;
                if (since_menu > bar_pkg::SETTLE_MS)
                begin
                    if (st.reset_pending)
                    begin
                        st_next.reset_pending = 1'b0;
                        res_valid             = 1'b1;
                        res.action            = bar_pkg::ACT_RESET;
                        res.display_value     = st.current_value;
                        res.saved_value       = bar_pkg::saturate(cfg.value_kind,
                                                                  cfg.min_value);
                    end
                    else if (st.enter_pending)
                    begin
                        if (!item.enter_level)
                        begin
                            st_next.was_pressed   = 1'b0;
                            st_next.enter_pending = 1'b0;
                        end
                        else if (!st.was_pressed || repeat_due)
                        begin
                            // first step of a press also restarts the hold timer
                            if (!st.was_pressed)
                            begin
                                st_next.was_pressed      = 1'b1;
                                st_next.press_start_time = now_t;
                            end
                            st_next.last_repeat_time = now_t;
                            st_next.current_value    = step_sat;
                            res_valid                = 1'b1;
                            res.action               = bar_pkg::ACT_STEP;
                            res.display_value        = stepped;
                            res.saved_value          = step_sat;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

endmodule

>>> rtl/button_auto_repeat_adjuster.sv
// Button auto-repeat adjuster: beat registers, state registers and checks.
//
// Use: in_data beats (tick, switch hit, menu change) enter on in_valid/in_ready.
// Each beat gives zero or one result beat on out_valid/out_ready.
// Configuration is written on cfg_valid/cfg_ready (always ready) with
// cfg_index selecting the register; write only while no beat is in flight.
// The input beat is held in the input register and its result in the result
// register, which drives out_valid; a stalled receiver can keep the beat in
// the input register before its result is registered.
// Throughput: 1 beat per cycle while out_ready is high; the update logic
// between the input register and the result register is combinational.
// A stalled receiver holds the result register; the input register still
// takes one more beat, after which in_ready drops until out_ready returns.
// Reset clears all timers, flags and the held value, and loads the register
// defaults; no beats are pending after reset.
`timescale 1ns / 1ps
`include "button_auto_repeat_adjuster_defines.svh"

module button_auto_repeat_adjuster (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  bar_pkg::in_item_t             in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output bar_pkg::out_item_t            out_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bar_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bar_pkg::VALUE_W-1:0]   cfg_data
);

    bar_pkg::cfg_t      cfg;
    bar_pkg::state_t    state_reg;
    bar_pkg::state_t    state_next;
    bar_pkg::in_item_t  in_item_reg;
    bar_pkg::out_item_t out_data_reg;
    bar_pkg::out_item_t res;
    logic               in_valid_reg;
    logic               out_valid_reg;
    logic               res_valid;
    logic               advance;

    assign cfg_ready = 1'b1;

    bar_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid & cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    bar_step u_step (
        .cfg       (cfg),
        .st        (state_reg),
        .item      (in_item_reg),
        .st_next   (state_next),
        .res_valid (res_valid),
        .res       (res)
    );

    // the held beat moves on once the result slot is free or being emptied
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (advance)
            begin
                state_reg     <= state_next;
                out_valid_reg <= res_valid;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            in_item_reg <= in_data;
        if (advance && res_valid)
            out_data_reg <= res;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `BAR_ASSERT_IMPL(a_ready_when_slot_empty, !out_valid_reg, in_ready)
    `BAR_ASSERT_NEXT(a_no_result_from_nothing, !out_valid_reg && !in_valid_reg, !out_valid_reg)
    `BAR_ASSERT_IMPL(a_byte_kind_saturated,
                     out_valid_reg && (cfg.value_kind == bar_pkg::KIND_BYTE),
                     out_data_reg.saved_value <= bar_pkg::BYTE_LIMIT)

endmodule
